// File: rtl/sia_pkg.sv
// shared types and constants for the signed add/sub/mul/div unit
// no dependencies; imported by signed_int_add_sub_mul_div_unit
`default_nettype none

package sia_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_t;

  typedef struct packed {
    op_t                       opcode;
    logic signed [WORD_W-1:0]  operand_a;
    logic signed [WORD_W-1:0]  operand_b;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  result;
    logic                      divide_by_zero;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/signed_int_add_sub_mul_div_unit.sv
// signed 32-bit add / subtract / multiply / divide unit, bit-serial mul and div
// depends on sia_pkg (types, opcodes, word width)
// add/sub and zero divisor: ST_IDLE straight to ST_FIX; mul/div: ST_IDLE, ST_RUN, ST_FIX
// one transaction at a time (in_ready only in ST_IDLE); ST_RUN uses the shared shift-add /
//   shift-subtract datapath, retiring one operand bit per cycle
// reset: synchronous active-low rst_n clears the sequencer and the output valid
`default_nettype none

module signed_int_add_sub_mul_div_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire sia_pkg::in_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output sia_pkg::out_t     out_data
);
  import sia_pkg::*;

  // two's complement negate within the word
  function automatic logic [WORD_W-1:0] neg_w(input logic [WORD_W-1:0] v);
    neg_w = ~v + {{(WORD_W-1){1'b0}}, 1'b1};
  endfunction

  // sequencer
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // datapath: acc_r is product or partial remainder, x_r is shifting
  // multiplicand or dividend/quotient, y_r is shifting multiplier or divisor
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;
  logic [WORD_W-1:0] y_r, y_nxt;
  op_t               op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic              dz_r, dz_nxt;

  // output register, parts the engine from the result channel
  out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  // operand views
  logic [WORD_W-1:0] a_u, b_u, a_mag, b_mag;
  logic [WORD_W:0]   div_cand, div_diff;
  logic [WORD_W-1:0] fix_val;
  logic              in_acc, out_free;

  assign a_u   = in_data.operand_a;
  assign b_u   = in_data.operand_b;
  assign a_mag = a_u[WORD_W-1] ? neg_w(a_u) : a_u;
  assign b_mag = b_u[WORD_W-1] ? neg_w(b_u) : b_u;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // restoring divide step: shift in next dividend bit, trial subtract
  assign div_cand = {acc_r, x_r[WORD_W-1]};
  assign div_diff = div_cand - {1'b0, y_r};

  // quotient ends up in x_r, product in acc_r
  assign fix_val = (op_r == OP_DIV) ? x_r : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    dz_r  <= dz_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    op_nxt        = op_r;
    neg_nxt       = neg_r;
    dz_nxt        = dz_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_data.opcode;
          neg_nxt = 1'b0;
          dz_nxt  = 1'b0;
          x_nxt   = a_mag;
          y_nxt   = b_mag;
          cnt_nxt = CNT_W'(WORD_W - 1);
          unique case (in_data.opcode)
            OP_ADD: begin
              acc_nxt   = a_u + b_u;
              state_nxt = ST_FIX;
            end
            OP_SUB: begin
              acc_nxt   = a_u - b_u;
              state_nxt = ST_FIX;
            end
            OP_MUL: begin
              acc_nxt   = '0;
              neg_nxt   = a_u[WORD_W-1] ^ b_u[WORD_W-1];
              state_nxt = ST_RUN;
            end
            OP_DIV: begin
              if (b_u == '0) begin
                // zero divisor: all-ones result with flag, no iteration
                acc_nxt   = '1;
                op_nxt    = OP_MUL;
                dz_nxt    = 1'b1;
                state_nxt = ST_FIX;
              end else begin
                acc_nxt   = '0;
                neg_nxt   = a_u[WORD_W-1] ^ b_u[WORD_W-1];
                state_nxt = ST_RUN;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_RUN: begin
        if (op_r == OP_DIV) begin
          if (!div_diff[WORD_W]) begin
            acc_nxt = div_diff[WORD_W-1:0];
          end else begin
            acc_nxt = div_cand[WORD_W-1:0];
          end
          x_nxt = {x_r[WORD_W-2:0], !div_diff[WORD_W]};
        end else begin
          // shift-add on the multiplier's low bit
          if (y_r[0]) begin
            acc_nxt = acc_r + x_r;
          end
          x_nxt = {x_r[WORD_W-2:0], 1'b0};
          y_nxt = {1'b0, y_r[WORD_W-1:1]};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end

      ST_FIX: begin
        // sign fix and hand-off, waits while the output holds a transaction
        if (out_free) begin
          out_nxt.result         = neg_r ? neg_w(fix_val) : fix_val;
          out_nxt.divide_by_zero = dz_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // flagged divide always carries the all-ones result
  a_dz_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.result == {WORD_W{1'b1}})
    else $error("divide_by_zero set without all-ones result");

  // add and subtract skip the iteration
  a_addsub_fix: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.opcode == OP_ADD || in_data.opcode == OP_SUB)
      |=> state_r == ST_FIX)
    else $error("add/sub did not go straight to sign fix");

  // a ready sign-fix stage loads the output register
  a_fix_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIX && out_free |=> out_valid && state_r == ST_IDLE)
    else $error("finished transaction not presented");

  // iteration ends only after the last bit
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && cnt_r != '0 |=> state_r == ST_RUN)
    else $error("iteration left early");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for signed_int_add_sub_mul_div_unit
// drives directed and random transactions and checks every result against a built-in predictor
// depends on rtl/sia_pkg.sv and rtl/signed_int_add_sub_mul_div_unit.sv
`timescale 1ns / 100ps

module tb_top;
  import sia_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1100;
  // final stretch of the run with no idling on either side
  localparam int TAIL_ITEMS   = 120;
  // extra wait after the last awaited result, as margin for stray late results
  localparam int DRAIN_CYCLES = 40;
  // bound on the whole run, well above the slowest legal run of ~1130 transactions
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 60;

  localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  in_t   in_data   = '0;
  logic  out_ready = 1'b0;
  logic  in_ready;
  logic  out_valid;
  out_t  out_data;

  in_t   pending_ops[$];      // transactions not yet offered to the block
  out_t  awaited_results[$];  // predicted results, oldest first

  int    send_gap    = 0;
  int    recv_stall  = 0;
  int    cycle_cnt   = 0;
  int    error_cnt   = 0;
  int    checked_cnt = 0;
  int    op_seen[4]  = '{default: 0};
  int    zero_div_cnt = 0;

  signed_int_add_sub_mul_div_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // free-running clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // one line per mismatch, printing capped so a broken block keeps the log short
  task automatic report_mismatch(input string what);
    if (error_cnt < MAX_PRINTS)
      $display("mismatch @%0d: %s", cycle_cnt, what);
    error_cnt++;
  endtask

  // expected result of one transaction: wrapped add/sub, low product of the
  // magnitudes with a sign fix, quotient of the magnitudes truncated toward zero
  function automatic out_t compute_alu_result(input in_t item);
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    logic [WORD_W-1:0]   mag_a;
    logic [WORD_W-1:0]   mag_b;
    logic [WORD_W-1:0]   quot;
    logic [2*WORD_W-1:0] prod;
    logic                negate_out;
    out_t                res;
    a          = item.operand_a;
    b          = item.operand_b;
    // most-negative value keeps its bit pattern, read as 2^(W-1) unsigned
    mag_a      = a[WORD_W-1] ? -a : a;
    mag_b      = b[WORD_W-1] ? -b : b;
    negate_out = a[WORD_W-1] ^ b[WORD_W-1];
    res.divide_by_zero = 1'b0;
    case (item.opcode)
      OP_ADD: res.result = a + b;
      OP_SUB: res.result = a - b;
      OP_MUL: begin
        prod       = mag_a * mag_b;
        res.result = negate_out ? -prod[WORD_W-1:0] : prod[WORD_W-1:0];
      end
      default: begin
        if (b == '0) begin
          // zero divisor: all ones and the flag
          res.result         = '1;
          res.divide_by_zero = 1'b1;
        end else begin
          // most-negative / -1 wraps back to the most-negative value, no flag
          quot       = mag_a / mag_b;
          res.result = negate_out ? -quot : quot;
        end
      end
    endcase
    return res;
  endfunction

  task automatic queue_op(input op_t op, input logic signed [WORD_W-1:0] a,
                          input logic signed [WORD_W-1:0] b);
    in_t item;
    item.opcode    = op;
    item.operand_a = a;
    item.operand_b = b;
    pending_ops.push_back(item);
  endtask

  // operand mix: extremes, small and mid-size values, full-width random words
  function automatic logic [WORD_W-1:0] pick_operand();
    logic [15:0] half;
    case ($urandom_range(0, 11))
      0: return W_MIN;
      1: return W_MAX;
      2: return '1;
      3: return '0;
      4, 5: return WORD_W'(int'($urandom_range(0, 64)) - 32);
      6, 7: begin
        half = 16'($urandom());
        return WORD_W'($signed(half));
      end
      default: return WORD_W'($urandom());
    endcase
  endfunction

  // driver: offers queued transactions, valid held until accepted,
  // random gaps between transactions until the tail of the run
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(compute_alu_result(in_data));
        op_seen[in_data.opcode]++;
        if (in_data.opcode == OP_DIV && in_data.operand_b == '0)
          zero_div_cnt++;
      end
      // slot is free when nothing is held or the held transaction just went through
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
          if (pending_ops.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest prediction,
  // stalls the result channel in random bursts until the tail of the run
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_data.result));
        end else begin
          want = awaited_results.pop_front();
          checked_cnt++;
          if (out_data.result !== want.result)
            report_mismatch($sformatf("result got %0d want %0d",
                                      out_data.result, want.result));
          if (out_data.divide_by_zero !== want.divide_by_zero)
            report_mismatch($sformatf("divide_by_zero got %0b want %0b",
                                      out_data.divide_by_zero, want.divide_by_zero));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (pending_ops.size() > TAIL_ITEMS && $urandom_range(0, 6) == 0)
          recv_stall = $urandom_range(1, 15);
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    in_t item;
    logic timed_out;

    // directed: wrap points of add/sub
    queue_op(OP_ADD, W_MAX, 1);
    queue_op(OP_ADD, W_MIN, -1);
    queue_op(OP_ADD, '1, '1);
    queue_op(OP_SUB, W_MIN, 1);
    queue_op(OP_SUB, W_MAX, -1);
    queue_op(OP_SUB, '0, W_MIN);
    // multiply with the most-negative value and other extremes
    queue_op(OP_MUL, W_MIN, -1);
    queue_op(OP_MUL, W_MIN, W_MIN);
    queue_op(OP_MUL, W_MAX, W_MAX);
    queue_op(OP_MUL, W_MIN, 1);
    queue_op(OP_MUL, '0, W_MAX);
    queue_op(OP_MUL, -7, 6);
    // zero divisor with positive, negative and zero dividends
    queue_op(OP_DIV, 5, 0);
    queue_op(OP_DIV, W_MIN, 0);
    queue_op(OP_DIV, 0, 0);
    // most-negative dividend, including the overflowing -1 divisor
    queue_op(OP_DIV, W_MIN, -1);
    queue_op(OP_DIV, W_MIN, 1);
    queue_op(OP_DIV, W_MIN, 7);
    // most-negative divisor
    queue_op(OP_DIV, W_MIN, W_MIN);
    queue_op(OP_DIV, W_MAX, W_MIN);
    queue_op(OP_DIV, -1, W_MIN);
    // truncation toward zero with mixed signs, then exact and zero quotients
    queue_op(OP_DIV, -7, 2);
    queue_op(OP_DIV, 7, -2);
    queue_op(OP_DIV, W_MAX, W_MAX);
    queue_op(OP_DIV, 0, 5);

    // random transactions, every opcode, divisor zero now and then
    repeat (RANDOM_ITEMS) begin
      item.opcode    = op_t'($urandom_range(0, 3));
      item.operand_a = pick_operand();
      item.operand_b = pick_operand();
      if (item.opcode == OP_DIV && $urandom_range(0, 11) == 0)
        item.operand_b = '0;
      pending_ops.push_back(item);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every transaction to be accepted and answered
    while (!(pending_ops.size() == 0 && !in_valid && awaited_results.size() == 0)
           && cycle_cnt < CYCLE_LIMIT)
      @(negedge clk);
    timed_out = (cycle_cnt >= CYCLE_LIMIT);
    // let any stray late result show up
    if (!timed_out)
      repeat (DRAIN_CYCLES) @(negedge clk);

    if (timed_out)
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, awaited_results.size());
    else
      while (awaited_results.size() > 0) begin
        item = '0;
        report_mismatch($sformatf("missing result, predicted %0d",
                                  awaited_results[0].result));
        void'(awaited_results.pop_front());
      end

    $display("exercised %0d add, %0d sub, %0d mul, %0d div (%0d by zero) in %0d cycles",
             op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL], op_seen[OP_DIV],
             zero_div_cnt, cycle_cnt);
    $display("%0d results compared, %0d mismatches", checked_cnt, error_cnt);
    if (!timed_out && error_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
